// ----- rtl/core/pcd2_pkg.sv -----
// shared types, codes and constants for the 2d current deposition unit
// depends on nothing; used by the top level and its checker
package pcd2_pkg;

   // default sizes
   localparam int MAX_CELLS_X_DEF = 64;
   localparam int MAX_CELLS_Y_DEF = 64;
   localparam int ACC_WIDTH_DEF   = 48;

   // fixed point
   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   localparam logic [16:0] ONE_W     = 17'h1_0000;
   localparam int          DIV_STEPS = 48;
   localparam int          DIV_CW    = 6;

   // command codes
   localparam logic [1:0] CMD_DEPOSIT    = 2'd0;
   localparam logic [1:0] CMD_READ       = 2'd1;
   localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

   // result kinds
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_BATCH = 1'b1;

   // register indexes
   localparam int          CSR_IW           = 3;
   localparam logic [2:0]  REG_CHARGE       = 3'd0;
   localparam logic [2:0]  REG_CELL_WIDTH_X = 3'd1;
   localparam logic [2:0]  REG_CELL_WIDTH_Y = 3'd2;
   localparam logic [2:0]  REG_CELLS_X      = 3'd3;
   localparam logic [2:0]  REG_CELLS_Y      = 3'd4;

   // register reset values
   localparam logic [31:0] CHARGE_RST  = ONE_Q16;
   localparam logic [31:0] WIDTH_RST   = ONE_Q16;
   localparam logic [6:0]  CELLS_RST   = 7'd64;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CUR,
      ST_PREP,
      ST_MUL,
      ST_WR,
      ST_REPORT,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

   // restoring divider lane: remainder and dividend/quotient shift word
   typedef struct packed {
      logic [31:0] rem;
      logic [47:0] dq;
   } div_type;

   function automatic div_type div_step(input div_type s, input logic [31:0] d);
      logic [32:0] sh;
      logic [32:0] df;
      div_type     r;
      sh = {s.rem, s.dq[47]};
      df = sh - {1'b0, d};
      if (!df[32]) begin
         r.rem = df[31:0];
         r.dq  = {s.dq[46:0], 1'b1};
      end else begin
         r.rem = sh[31:0];
         r.dq  = {s.dq[46:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/pic_current_deposition_2d_unit.sv -----
// top level of the 2d cloud-in-cell current deposition unit
// holds the sequencer, the divider lanes and the three accumulator memories
// depends on pcd2_pkg
//
// channel   direction  handshake                     payload
// req       in         start & !busy                 command, position, velocity, gamma, cell
// rsp       out        rsp_strobe, one cycle          kind, sum_x/y/z, dropped
// csr       in         csr_valid & csr_ready          csr_index, csr_data
//
// deposit: accept, then the bit-serial divide, the current, and per neighbor cell a
//   prepare, multiply and write (prepare only if skipped), then the batch report on the
//   last particle; off the grid the neighbor steps are left out; each write is a
//   read-modify-write of the cell through the registered memory read
// read: an issue state, then the result; command 3 is accepted and gives nothing
// after reset a clearing pass over every cell zeroes the memories
//   with busy high; csr is always ready
// the receiver cannot stall: each result is shown for exactly one cycle
module pic_current_deposition_2d_unit #(
   parameter int MAX_CELLS_X = pcd2_pkg::MAX_CELLS_X_DEF,
   parameter int MAX_CELLS_Y = pcd2_pkg::MAX_CELLS_Y_DEF,
   parameter int ACC_WIDTH   = pcd2_pkg::ACC_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [31:0]                req_pos_x,
   input  logic [31:0]                req_pos_y,
   input  logic signed [31:0]         req_vel_x,
   input  logic signed [31:0]         req_vel_y,
   input  logic signed [31:0]         req_vel_z,
   input  logic [31:0]                req_lorentz_factor,
   input  logic [11:0]                req_cell_index,
   input  logic                       req_last_particle,
   output logic                       rsp_strobe,
   output logic                       rsp_kind,
   output logic signed [47:0]         rsp_sum_x,
   output logic signed [47:0]         rsp_sum_y,
   output logic signed [47:0]         rsp_sum_z,
   output logic [15:0]                rsp_dropped,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pcd2_pkg::CSR_IW-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_CELLS_X);
   localparam int YW    = $clog2(MAX_CELLS_Y);
   localparam int CXW   = $clog2(MAX_CELLS_X + 1);
   localparam int CYW   = $clog2(MAX_CELLS_Y + 1);
   localparam int SUM_W = (ACC_WIDTH > 48 ? ACC_WIDTH : 48) + 1;

   localparam logic signed [SUM_W-1:0] ACC_HI =
      {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;
   localparam logic signed [SUM_W-1:0] OUT_HI = {{(SUM_W-47){1'b0}}, {47{1'b1}}};
   localparam logic signed [SUM_W-1:0] OUT_LO = ~OUT_HI;

   // saturating accumulate of one part
   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [47:0] p);
      logic signed [SUM_W-1:0] ea;
      logic signed [SUM_W-1:0] ep;
      logic signed [SUM_W-1:0] s;
      ea = {{(SUM_W-ACC_WIDTH){a[ACC_WIDTH-1]}}, a};
      ep = {{(SUM_W-48){p[47]}}, p};
      s  = ea + ep;
      if (s > ACC_HI) begin
         return ACC_HI[ACC_WIDTH-1:0];
      end else if (s < ACC_LO) begin
         return ACC_LO[ACC_WIDTH-1:0];
      end
      return s[ACC_WIDTH-1:0];
   endfunction

   // clip a stored sum to the 48-bit result field
   function automatic logic [47:0] clip48(input logic [ACC_WIDTH-1:0] a);
      logic signed [SUM_W-1:0] e;
      e = {{(SUM_W-ACC_WIDTH){a[ACC_WIDTH-1]}}, a};
      if (e > OUT_HI) begin
         return OUT_HI[47:0];
      end else if (e < OUT_LO) begin
         return OUT_LO[47:0];
      end
      return e[47:0];
   endfunction

   // configuration registers
   logic [31:0] charge_ff;
   logic [31:0] width_x_ff;
   logic [31:0] width_y_ff;
   logic [6:0]  cells_x_ff;
   logic [6:0]  cells_y_ff;

   // control state
   pcd2_pkg::state_type state_ff, state_in;
   logic [pcd2_pkg::DIV_CW-1:0] div_cnt_ff;
   logic [AW-1:0]               clr_cnt_ff;
   logic [1:0]                  nb_ff;
   logic [15:0]                 drop_ff;

   // payload registers
   pcd2_pkg::div_type div_x_ff, div_y_ff, div_t_ff;
   logic [31:0]               dvs_x_ff, dvs_y_ff, dvs_t_ff;
   logic                      neg_ff;
   logic                      last_ff;
   logic                      clear_ff;
   logic                      in_range_ff;
   logic [AW-1:0]             rd_idx_ff;
   logic signed [31:0]        vel_x_ff, vel_y_ff, vel_z_ff;
   logic signed [47:0]        cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [47:0]        part_x_ff, part_y_ff, part_z_ff;
   logic [XW-1:0]             x1_ff, x2_ff;
   logic [YW-1:0]             y1_ff, y2_ff;
   logic [15:0]               fx_ff, fy_ff;
   logic [16:0]               w_ff;
   logic [AW-1:0]             addr_ff;

   // memories
   logic [ACC_WIDTH-1:0] mem_x [DEPTH];
   logic [ACC_WIDTH-1:0] mem_y [DEPTH];
   logic [ACC_WIDTH-1:0] mem_z [DEPTH];
   logic [ACC_WIDTH-1:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [ACC_WIDTH-1:0] wr_x, wr_y, wr_z;

   // combinational helpers
   logic [CXW-1:0] cx;
   logic [CYW-1:0] cy;
   logic           accept;
   logic           in_grid;
   logic           skip;
   logic           last_nb;
   logic [CXW-1:0] nx;
   logic [CYW-1:0] ny;
   logic signed [32:0] t_val;
   logic signed [64:0] prod_x, prod_y, prod_z;
   logic [XW-1:0]  col;
   logic [YW-1:0]  row;
   logic [16:0]    wx, wy;
   logic [33:0]    wprod;
   logic [31:0]    addr_full;
   logic signed [17:0] w_s;
   logic signed [65:0] pp_x, pp_y, pp_z;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // grid size clamped to 1..MAX
   always_comb begin
      if (cells_x_ff == 7'd0) begin
         cx = CXW'(1);
      end else if (32'(cells_x_ff) > 32'(MAX_CELLS_X)) begin
         cx = CXW'(MAX_CELLS_X);
      end else begin
         cx = CXW'(cells_x_ff);
      end
      if (cells_y_ff == 7'd0) begin
         cy = CYW'(1);
      end else if (32'(cells_y_ff) > 32'(MAX_CELLS_Y)) begin
         cy = CYW'(MAX_CELLS_Y);
      end else begin
         cy = CYW'(cells_y_ff);
      end
   end

   // integer part of each quotient against the grid size
   assign in_grid = (div_x_ff.dq[47:16] < 32'(cx)) && (div_y_ff.dq[47:16] < 32'(cy));

   // wrapped neighbor column and row
   assign nx = CXW'(div_x_ff.dq[16+XW-1:16]) + CXW'(1);
   assign ny = CYW'(div_y_ff.dq[16+YW-1:16]) + CYW'(1);

   // t = charge / gamma, sign restored, then the three currents
   assign t_val  = neg_ff ? -$signed({1'b0, div_t_ff.dq[31:0]})
                          : $signed({1'b0, div_t_ff.dq[31:0]});
   assign prod_x = t_val * vel_x_ff;
   assign prod_y = t_val * vel_y_ff;
   assign prod_z = t_val * vel_z_ff;

   // neighbor select: bit 1 picks the next column, bit 0 the next row
   assign skip    = (nb_ff[1] && x2_ff == '0) || (nb_ff[0] && y2_ff == '0);
   assign last_nb = (nb_ff == 2'd3);
   assign col     = nb_ff[1] ? x2_ff : x1_ff;
   assign row     = nb_ff[0] ? y2_ff : y1_ff;
   assign wx      = nb_ff[1] ? {1'b0, fx_ff} : pcd2_pkg::ONE_W - {1'b0, fx_ff};
   assign wy      = nb_ff[0] ? {1'b0, fy_ff} : pcd2_pkg::ONE_W - {1'b0, fy_ff};
   assign wprod   = wx * wy;
   assign addr_full = 32'(row) + 32'(cy) * 32'(col);

   // part = floor(current * weight)
   assign w_s  = $signed({1'b0, w_ff});
   assign pp_x = cur_x_ff * w_s;
   assign pp_y = cur_y_ff * w_s;
   assign pp_z = cur_z_ff * w_s;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcd2_pkg::ST_CLEAR: begin
            if (32'(clr_cnt_ff) == 32'(DEPTH - 1)) begin
               state_in = pcd2_pkg::ST_IDLE;
            end
         end
         pcd2_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  pcd2_pkg::CMD_DEPOSIT: state_in = pcd2_pkg::ST_DIV;
                  pcd2_pkg::CMD_READ, pcd2_pkg::CMD_READ_CLEAR:
                     state_in = pcd2_pkg::ST_RD_ISSUE;
                  default: state_in = pcd2_pkg::ST_IDLE;
               endcase
            end
         end
         pcd2_pkg::ST_DIV: begin
            if (div_cnt_ff == pcd2_pkg::DIV_CW'(pcd2_pkg::DIV_STEPS - 1)) begin
               state_in = pcd2_pkg::ST_CUR;
            end
         end
         pcd2_pkg::ST_CUR: begin
            if (in_grid) begin
               state_in = pcd2_pkg::ST_PREP;
            end else begin
               state_in = last_ff ? pcd2_pkg::ST_REPORT : pcd2_pkg::ST_IDLE;
            end
         end
         pcd2_pkg::ST_PREP: begin
            if (!skip) begin
               state_in = pcd2_pkg::ST_MUL;
            end else if (last_nb) begin
               state_in = last_ff ? pcd2_pkg::ST_REPORT : pcd2_pkg::ST_IDLE;
            end
         end
         pcd2_pkg::ST_MUL: state_in = pcd2_pkg::ST_WR;
         pcd2_pkg::ST_WR: begin
            if (last_nb) begin
               state_in = last_ff ? pcd2_pkg::ST_REPORT : pcd2_pkg::ST_IDLE;
            end else begin
               state_in = pcd2_pkg::ST_PREP;
            end
         end
         pcd2_pkg::ST_REPORT:   state_in = pcd2_pkg::ST_IDLE;
         pcd2_pkg::ST_RD_ISSUE: state_in = pcd2_pkg::ST_RD_DATA;
         pcd2_pkg::ST_RD_DATA:  state_in = pcd2_pkg::ST_IDLE;
         default:               state_in = pcd2_pkg::ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      busy        = (state_ff != pcd2_pkg::ST_IDLE);
      rsp_strobe  = 1'b0;
      rsp_kind    = pcd2_pkg::KIND_CELL;
      rsp_sum_x   = '0;
      rsp_sum_y   = '0;
      rsp_sum_z   = '0;
      rsp_dropped = '0;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_x        = '0;
      wr_y        = '0;
      wr_z        = '0;
      rd_addr     = (state_ff == pcd2_pkg::ST_RD_ISSUE) ? rd_idx_ff : addr_ff;
      unique case (state_ff)
         pcd2_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
         end
         pcd2_pkg::ST_WR: begin
            wr_en = 1'b1;
            wr_x  = sat_add(rd_x_ff, part_x_ff);
            wr_y  = sat_add(rd_y_ff, part_y_ff);
            wr_z  = sat_add(rd_z_ff, part_z_ff);
         end
         pcd2_pkg::ST_REPORT: begin
            rsp_strobe  = 1'b1;
            rsp_kind    = pcd2_pkg::KIND_BATCH;
            rsp_dropped = drop_ff;
         end
         pcd2_pkg::ST_RD_DATA: begin
            rsp_strobe = 1'b1;
            wr_addr    = rd_idx_ff;
            // a read and clear of a cell in range zeroes it as it is shown
            wr_en      = clear_ff && in_range_ff;
            if (in_range_ff) begin
               rsp_sum_x = clip48(rd_x_ff);
               rsp_sum_y = clip48(rd_y_ff);
               rsp_sum_z = clip48(rd_z_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pcd2_pkg::ST_CLEAR;
         div_cnt_ff <= '0;
         clr_cnt_ff <= '0;
         nb_ff      <= '0;
         drop_ff    <= '0;
         charge_ff  <= pcd2_pkg::CHARGE_RST;
         width_x_ff <= pcd2_pkg::WIDTH_RST;
         width_y_ff <= pcd2_pkg::WIDTH_RST;
         cells_x_ff <= pcd2_pkg::CELLS_RST;
         cells_y_ff <= pcd2_pkg::CELLS_RST;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pcd2_pkg::REG_CHARGE:       charge_ff  <= csr_data;
               pcd2_pkg::REG_CELL_WIDTH_X: width_x_ff <= csr_data;
               pcd2_pkg::REG_CELL_WIDTH_Y: width_y_ff <= csr_data;
               pcd2_pkg::REG_CELLS_X:      cells_x_ff <= csr_data[6:0];
               pcd2_pkg::REG_CELLS_Y:      cells_y_ff <= csr_data[6:0];
               default: begin
               end
            endcase
         end
         if (state_ff == pcd2_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (state_ff == pcd2_pkg::ST_IDLE) begin
            div_cnt_ff <= '0;
         end else if (state_ff == pcd2_pkg::ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + pcd2_pkg::DIV_CW'(1);
         end
         if (state_ff == pcd2_pkg::ST_CUR) begin
            nb_ff <= '0;
            if (!in_grid && drop_ff != 16'hFFFF) begin
               drop_ff <= drop_ff + 16'd1;
            end
         end else if ((state_ff == pcd2_pkg::ST_PREP && skip) ||
                      state_ff == pcd2_pkg::ST_WR) begin
            nb_ff <= nb_ff + 2'd1;
         end
         if (state_ff == pcd2_pkg::ST_REPORT) begin
            drop_ff <= '0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == pcd2_pkg::ST_IDLE && accept) begin
         div_x_ff.rem <= '0;
         div_x_ff.dq  <= {req_pos_x, 16'h0000};
         div_y_ff.rem <= '0;
         div_y_ff.dq  <= {req_pos_y, 16'h0000};
         div_t_ff.rem <= '0;
         div_t_ff.dq  <= {(charge_ff[31] ? -charge_ff : charge_ff), 16'h0000};
         neg_ff       <= charge_ff[31];
         dvs_x_ff     <= (width_x_ff == '0) ? 32'd1 : width_x_ff;
         dvs_y_ff     <= (width_y_ff == '0) ? 32'd1 : width_y_ff;
         dvs_t_ff     <= (req_lorentz_factor < pcd2_pkg::ONE_Q16) ? pcd2_pkg::ONE_Q16
                                                                  : req_lorentz_factor;
         vel_x_ff     <= req_vel_x;
         vel_y_ff     <= req_vel_y;
         vel_z_ff     <= req_vel_z;
         last_ff      <= req_last_particle;
         clear_ff     <= (req_command == pcd2_pkg::CMD_READ_CLEAR);
         in_range_ff  <= (32'(req_cell_index) < 32'(DEPTH));
         rd_idx_ff    <= AW'(req_cell_index);
      end
      if (state_ff == pcd2_pkg::ST_DIV) begin
         div_x_ff <= pcd2_pkg::div_step(div_x_ff, dvs_x_ff);
         div_y_ff <= pcd2_pkg::div_step(div_y_ff, dvs_y_ff);
         div_t_ff <= pcd2_pkg::div_step(div_t_ff, dvs_t_ff);
      end
      if (state_ff == pcd2_pkg::ST_CUR) begin
         cur_x_ff <= prod_x[63:16];
         cur_y_ff <= prod_y[63:16];
         cur_z_ff <= prod_z[63:16];
         x1_ff    <= div_x_ff.dq[16+XW-1:16];
         y1_ff    <= div_y_ff.dq[16+YW-1:16];
         x2_ff    <= (nx == cx) ? '0 : nx[XW-1:0];
         y2_ff    <= (ny == cy) ? '0 : ny[YW-1:0];
         fx_ff    <= div_x_ff.dq[15:0];
         fy_ff    <= div_y_ff.dq[15:0];
      end
      if (state_ff == pcd2_pkg::ST_PREP) begin
         w_ff    <= wprod[32:16];
         addr_ff <= addr_full[AW-1:0];
      end
      if (state_ff == pcd2_pkg::ST_MUL) begin
         part_x_ff <= pp_x[63:16];
         part_y_ff <= pp_y[63:16];
         part_z_ff <= pp_z[63:16];
      end
   end

   // accumulator memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
         mem_z[wr_addr] <= wr_z;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_z_ff <= mem_z[rd_addr];
   end

endmodule

// ----- rtl/core/pcd2_checker.sv -----
// port-level checks for the 2d current deposition unit
// depends on pcd2_pkg; bound to pic_current_deposition_2d_unit below
module pcd2_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [1:0]                  req_command,
   input logic                        rsp_strobe,
   input logic                        rsp_kind,
   input logic [15:0]                 rsp_dropped
);

   // results are single-cycle and never back to back
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("two result strobes in a row");

   // a result only comes while the unit is busy
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result while idle");

   // cell reads never report drops
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == pcd2_pkg::KIND_CELL) |-> rsp_dropped == 16'd0)
      else $error("cell read with nonzero drop count");

   // a read transfer keeps the unit busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == pcd2_pkg::CMD_READ ||
                          req_command == pcd2_pkg::CMD_READ_CLEAR)) |=> busy)
      else $error("read transfer without busy");

   // the clearing pass follows reset
   assert property (@(posedge clock) $past(reset) |-> busy)
      else $error("idle right after reset");

endmodule

bind pic_current_deposition_2d_unit pcd2_checker u_pcd2_checker (.*);
